[sv/fqd_pkg.sv]
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and constants for the FIFO queue with delete-by-value.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int VALUE_W       = 32;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_DEQUEUE = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_LENGTH  = 2'd3
  } kind_t;

  // Command broadcast to every cell of the chain for one accepted item.
  typedef struct packed {
    logic               enq;    // append at the tail slot
    logic               deq;    // every cell takes its neighbor's entry
    logic               del;    // cells at/after the oldest match close up
    logic [VALUE_W-1:0] value;  // handle to append or look for
  } cell_cmd_t;

endpackage

[sv/fqd_in_if.sv]
// ----------------------------------------------------------------------------
// fqd_in_if
// Operation channel: valid/ready handshake with kind and handle payload.
// ----------------------------------------------------------------------------
interface fqd_in_if;
  logic                        valid;
  logic                        ready;
  fqd_pkg::kind_t              kind;
  logic [fqd_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, output kind, output item_value, input ready);
  modport sink   (input valid, input kind, input item_value, output ready);
endinterface

[sv/fqd_out_if.sv]
// ----------------------------------------------------------------------------
// fqd_out_if
// Result channel: valid/ready handshake with status, handle and count.
// ----------------------------------------------------------------------------
interface fqd_out_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic [fqd_pkg::VALUE_W-1:0]       value_out;
  logic [fqd_pkg::ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  output ready);
endinterface

[sv/fqd_cell.sv]
// ----------------------------------------------------------------------------
// fqd_cell
// One queue slot: holds an entry, compares it, and shifts toward the head.
// ----------------------------------------------------------------------------
module fqd_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                        clk,
  input  fqd_pkg::cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]            count,
  input  logic [fqd_pkg::VALUE_W-1:0] nbr_value,  // entry of the next slot
  input  logic                        hit_in,     // match in an older slot
  output logic                        hit_out,
  output logic [fqd_pkg::VALUE_W-1:0] value
);

  logic [fqd_pkg::VALUE_W-1:0] value_r;
  logic [fqd_pkg::VALUE_W-1:0] value_nxt;
  logic                        occupied;
  logic                        match;
  logic                        shift;
  logic                        load;

  assign occupied = CNT_W'(IDX) < count;
  assign match    = occupied && (value_r == cmd.value);
  assign hit_out  = hit_in || match;
  assign shift    = cmd.deq || (cmd.del && hit_out);
  assign load     = cmd.enq && (count == CNT_W'(IDX));
  assign value    = value_r;

  always_comb begin
    if (shift) begin
      value_nxt = nbr_value;
    end else if (load) begin
      value_nxt = cmd.value;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[sv/fifo_queue_with_delete.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded FIFO of nonzero 32-bit handles with delete of the oldest match.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH slot cells, slot 0 the head. Each accepted item
// acts on the whole row: every cell compares its entry against the handle at
// once, a hit flag ripples down the row to find the oldest match, and on a
// dequeue or delete each affected cell copies its neighbor's entry, so the
// entries behind the removed one close up in order. An enqueue writes the
// slot addressed by the occupancy counter. The result lands in an output
// register at the edge that accepts the item; a new item is taken whenever that
// register is empty or is being drained, so the sustained rate is one item
// per cycle, limited by the compare-and-priority path across the cell row.
// status is 1 for a null handle, enqueue on full, dequeue on empty, or a
// delete without a match; such items leave the queue unchanged. entry_count
// is the count after the item, kept to its low five bits. Entries of slots
// never written are not cleared after reset; they are never read.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete #(
  parameter int DEPTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  fqd_in_if.sink   in_ch,
  fqd_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // occupancy and the output register
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              status_r, status_nxt;
  logic [fqd_pkg::VALUE_W-1:0]       value_out_r, value_out_nxt;
  logic [fqd_pkg::ENTRY_COUNT_W-1:0] entry_count_r, entry_count_nxt;

  logic               accept;
  logic               found;     // some occupied slot holds the handle
  logic               null_val;
  fqd_pkg::cell_cmd_t cmd;

  logic [fqd_pkg::VALUE_W-1:0] cell_value [DEPTH];
  logic [DEPTH:0]              hit_chain;

  // Output register frees up as it drains, so input stays open meanwhile.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign null_val    = (in_ch.item_value == '0);

  // ---- cell row ----
  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [fqd_pkg::VALUE_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_tail
      assign nbr = cell_value[i];  // last slot: vacated, contents don't matter
    end else begin : g_mid
      assign nbr = cell_value[i+1];
    end

    fqd_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .nbr_value (nbr),
      .hit_in    (hit_chain[i]),
      .hit_out   (hit_chain[i+1]),
      .value     (cell_value[i])
    );
  end

  // ---- decode and result ----
  always_comb begin
    cmd.enq       = 1'b0;
    cmd.deq       = 1'b0;
    cmd.del       = 1'b0;
    cmd.value     = in_ch.item_value;
    count_nxt     = count_r;
    status_nxt    = status_r;
    value_out_nxt = value_out_r;
    out_valid_nxt = out_valid_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = 1'b0;
      value_out_nxt = '0;
      case (in_ch.kind)
        fqd_pkg::KIND_ENQUEUE: begin
          if (null_val || (count_r == CNT_W'(DEPTH))) begin
            status_nxt = 1'b1;
          end else begin
            cmd.enq   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        fqd_pkg::KIND_DEQUEUE: begin
          if (count_r == '0) begin
            status_nxt = 1'b1;
          end else begin
            cmd.deq       = 1'b1;
            value_out_nxt = cell_value[0];
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        fqd_pkg::KIND_DELETE: begin
          if (null_val || !found) begin
            status_nxt = 1'b1;
          end else begin
            cmd.del   = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        fqd_pkg::KIND_LENGTH: begin
          status_nxt = 1'b0;
        end
        default: begin
          status_nxt = 1'b0;
        end
      endcase
    end

    entry_count_nxt = fqd_pkg::ENTRY_COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    value_out_r   <= value_out_nxt;
    entry_count_r <= entry_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.value_out   = value_out_r;
  assign out_ch.entry_count = entry_count_r;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above DEPTH");

  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.kind == fqd_pkg::KIND_DEQUEUE) && (count_r == '0)
    |=> out_valid_r && status_r && (value_out_r == '0) && (count_r == '0))
    else $error("dequeue on empty not flagged");

  a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.kind == fqd_pkg::KIND_ENQUEUE) && !null_val
      && (count_r != CNT_W'(DEPTH))
    |=> (count_r == $past(count_r) + CNT_W'(1)) && !status_r)
    else $error("enqueue did not grow the queue");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("item taken while result stalled");

  a_del_miss: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.kind == fqd_pkg::KIND_DELETE) && !found
    |=> status_r && (count_r == $past(count_r)))
    else $error("delete without match changed the queue");

endmodule

[test/fqd_result_checker.sv]
// ----------------------------------------------------------------------------
// fqd_result_checker
// Watches both channels of the handle queue and predicts every result.
// ----------------------------------------------------------------------------
// A shadow copy of the queue is updated for every accepted operation. The
// result it gives is pushed to a list of expected results. Each accepted
// result is compared field by field with the oldest entry of that list.
// ----------------------------------------------------------------------------
module fqd_result_checker
  import fqd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  fqd_in_if    in_mon,
  fqd_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic                     status;
    logic [VALUE_W-1:0]       value_out;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } queue_result_t;

  logic [VALUE_W-1:0] shadow_entries [$];   // index 0 is the head
  queue_result_t      expected_results [$];

  // Apply one operation to the shadow queue and return its result.
  function automatic queue_result_t apply_queue_op(kind_t op, logic [VALUE_W-1:0] handle);
    queue_result_t res;
    int            hit;
    res.status    = 1'b0;
    res.value_out = '0;
    hit           = -1;
    case (op)
      KIND_ENQUEUE: begin
        if (handle == '0 || shadow_entries.size() >= DEPTH) res.status = 1'b1;
        else shadow_entries.push_back(handle);
      end
      KIND_DEQUEUE: begin
        if (shadow_entries.size() == 0) res.status = 1'b1;
        else res.value_out = shadow_entries.pop_front();
      end
      KIND_DELETE: begin
        if (handle != '0) begin
          for (int i = 0; i < shadow_entries.size(); i++) begin
            if (hit < 0 && shadow_entries[i] == handle) hit = i;
          end
        end
        if (hit < 0) res.status = 1'b1;
        else shadow_entries.delete(hit);
      end
      default: ;
    endcase
    res.entry_count = ENTRY_COUNT_W'(shadow_entries.size());
    return res;
  endfunction

  task automatic check_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      shadow_entries.delete();
      expected_results.delete();
      pending <= 0;
    end else begin
      // results first: an item taken at this edge cannot have its result yet
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d value_out 0x%0h entry_count %0d",
                 out_mon.status, out_mon.value_out, out_mon.entry_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", VALUE_W'(want.status), VALUE_W'(out_mon.status));
          check_field("value_out", want.value_out, out_mon.value_out);
          check_field("entry_count", VALUE_W'(want.entry_count),
                      VALUE_W'(out_mon.entry_count));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(apply_queue_op(in_mon.kind, in_mon.item_value));
      end
      pending <= expected_results.size();
    end
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the handle queue with delete-by-value.
// ----------------------------------------------------------------------------
// A directed run covers the error cases, duplicates and a full queue. Random
// segments then lean toward filling, draining or a mix, with handles mostly
// from a small pool so deletes find matches and duplicates build up. Both
// sides idle at random; the receiver holds off once for a long stretch and
// the sender stops once until the queue of expected results is empty.
// ----------------------------------------------------------------------------
module testbench;
  import fqd_pkg::*;

  localparam int DEPTH          = 16;
  localparam int CLK_PERIOD     = 4;
  localparam int RANDOM_ITEMS   = 1324;
  localparam int POOL_SIZE      = 6;
  localparam int RX_HOLD_AT     = 400;    // result count at which the long hold starts
  localparam int RX_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 200000;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } op_mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   tx_count    = 0;   // items taken by the block so far

  logic [VALUE_W-1:0] handle_pool [POOL_SIZE];

  fqd_in_if  in_ch ();
  fqd_out_if out_ch ();

  fifo_queue_with_delete #(.DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fqd_result_checker #(.DEPTH(DEPTH)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] fresh_handle();
    logic [VALUE_W-1:0] v;
    v = $urandom();
    if (v == '0) v = 1;
    return v;
  endfunction

  // Mostly pool handles (matches, duplicates), some random misses, rare nulls.
  function automatic logic [VALUE_W-1:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 18) return $urandom();
    return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic kind_t pick_kind(op_mix_t mix);
    int roll;
    int enq_pct;
    int deq_pct;
    int del_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        enq_pct = 70; deq_pct = 10; del_pct = 10;
      end
      MIX_DRAIN: begin
        enq_pct = 15; deq_pct = 45; del_pct = 30;
      end
      default: begin
        enq_pct = 40; deq_pct = 25; del_pct = 25;
      end
    endcase
    if (roll < enq_pct) return KIND_ENQUEUE;
    if (roll < enq_pct + deq_pct) return KIND_DEQUEUE;
    if (roll < enq_pct + deq_pct + del_pct) return KIND_DELETE;
    return KIND_LENGTH;
  endfunction

  // Offer one item after a random gap; returns at the edge it is taken.
  // valid is only lowered when a gap is drawn, so back-to-back items keep it high.
  task automatic offer_op(kind_t op, logic [VALUE_W-1:0] handle);
    int gap;
    if ((tx_count / 50) % 4 == 3) gap = 0;   // no-idle stretch
    else gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op;
    in_ch.item_value <= handle;
    do @(posedge clk); while (!in_ch.ready);
    tx_count++;
  endtask

  // Stop offering until every expected result has come back.
  // pending is registered, so look only from the next edge on.
  task automatic wait_queue_settled();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stalls, a no-stall stretch, and one long hold.
  initial begin : result_sink
    int gap;
    int results_taken;
    results_taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken == RX_HOLD_AT) gap = RX_HOLD_CYCLES;
      else if ((results_taken / 70) % 4 == 1) gap = 0;
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_taken++;
    end
  end

  initial begin : op_source
    op_mix_t            mix;
    kind_t              op;
    logic [VALUE_W-1:0] v;
    int                 seg_len;
    int                 sent;

    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_LENGTH;
    in_ch.item_value <= '0;
    for (int i = 0; i < POOL_SIZE; i++) handle_pool[i] = fresh_handle();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    offer_op(KIND_LENGTH, 32'h0);            // length of an empty queue
    offer_op(KIND_DEQUEUE, 32'hFFFF_FFFF);   // dequeue on empty
    offer_op(KIND_ENQUEUE, 32'h0);           // null enqueue
    offer_op(KIND_DELETE, 32'h0);            // null delete
    offer_op(KIND_DELETE, 32'h5);            // delete on empty: no match
    offer_op(KIND_ENQUEUE, 32'hFFFF_FFFF);
    offer_op(KIND_ENQUEUE, 32'h1);
    offer_op(KIND_ENQUEUE, 32'hFFFF_FFFF);   // duplicate handle
    // fill to DEPTH, then one more enqueue bounces off the full queue
    for (int i = 0; i < DEPTH - 3; i++) offer_op(KIND_ENQUEUE, 32'h8000_0000 | i);
    offer_op(KIND_ENQUEUE, 32'h7FFF_FFFF);
    offer_op(KIND_DELETE, 32'hFFFF_FFFF);    // takes only the oldest duplicate
    offer_op(KIND_DELETE, 32'h1234_5678);    // no match, with DEPTH - 1 entries queued
    offer_op(KIND_DEQUEUE, 32'h0);
    offer_op(KIND_LENGTH, 32'hFFFF_FFFF);
    wait_queue_settled();

    // --- random part, in segments leaning one way ---
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix     = op_mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(20, 60);
      handle_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_handle();
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        if (sent == RANDOM_ITEMS / 2) wait_queue_settled();
        op = pick_kind(mix);
        if (op == KIND_ENQUEUE || op == KIND_DELETE) v = pick_handle();
        else v = $urandom();                 // field ignored, still toggled
        offer_op(op, v);
        sent++;
      end
    end

    wait_queue_settled();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
